// ===== rtl/mic_pkg.sv =====
// shared types and constants for the multiset intersection counter
package mic_pkg;
   localparam int unsigned ENTRIES   = 1024;
   localparam int unsigned IDX_W     = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
   localparam bit          IS_POW2   = ((ENTRIES & (ENTRIES - 1)) == 0);
   localparam int unsigned COUNT_W   = 11;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [31:0] HASH_MUL  = 32'd2654435761;

   // reciprocal of the table size for the hash remainder, scaled by 2^HASH_SHIFT
   localparam int unsigned HASH_SHIFT = 32 + IDX_W;
   localparam logic [32:0] HASH_RECIP = 33'((64'd1 << HASH_SHIFT) / 64'(ENTRIES));

   // action codes on the request side
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_PROBE = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_PROBE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] echo_value;
      logic               matched;
      logic               status;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] value;
   } work_type;

   typedef struct packed {
      logic               occupied;
      logic [COUNT_W-1:0] count;
      logic [31:0]        key;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);
endpackage

// ===== rtl/mic_ram.sv =====
// generic single-write, single-read ram with registered read data
module mic_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/mic_front.sv =====
// front end: request queue and action decode
module mic_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  mic_pkg::req_type  req_data,
   output logic              req_full,
   output logic              item_valid,
   output mic_pkg::work_type item,
   input  logic              item_take
);
   import mic_pkg::*;

   work_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   work_type   classified;

   // decode the action into an operation
   always_comb begin
      classified.value = req_data.value;
      unique case (req_data.action)
         ACT_LOAD:  classified.op = OP_LOAD;
         ACT_PROBE: classified.op = OP_PROBE;
         ACT_CLEAR: classified.op = OP_CLEAR;
         default:   classified.op = OP_NOP;
      endcase
   end

   assign req_full   = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];
   assign push       = req_push && !req_full;
   assign pop        = item_take && item_valid;

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= classified;
      end
   end
endmodule

// ===== rtl/mic_back.sv =====
// back end: hash, table walk, count update, table clear and result queue
module mic_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  mic_pkg::work_type item,
   output logic              item_take,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mic_pkg::rsp_type  rsp_data
);
   import mic_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_MIX  = 8'b00000010,
      ST_QUO  = 8'b00000100,
      ST_REM  = 8'b00001000,
      ST_FIX  = 8'b00010000,
      ST_RD   = 8'b00100000,
      ST_CMP  = 8'b01000000,
      ST_CLR  = 8'b10000000
   } state_type;

   state_type        state_ff, state_in;
   work_type         cur_ff, cur_in;
   logic [31:0]      mul_ff, mul_in;
   logic [31:0]      hash_ff, hash_in;
   logic [31:0]      quo_ff, quo_in;
   logic [IDX_W:0]   rem_ff, rem_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic             clr_rsp_ff, clr_rsp_in;

   logic             wr_en;
   entry_type        wr_entry;
   entry_type        rd_entry;
   logic [ENTRY_W-1:0] rd_raw;
   logic [31:0]      mix;
   logic [95:0]      recip_prod;
   logic [31:0]      rem_wide;
   logic [IDX_W:0]   rem_fix;
   logic [IDX_W-1:0] idx_step;

   logic             out_push;
   rsp_type          out_rsp;
   rsp_type          oq_ff [2];
   logic             owr_ff, owr_in, ord_ff, ord_in;
   logic [1:0]       ocnt_ff, ocnt_in;
   logic             out_pop;

   mic_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_entry),
      .rd_addr (idx_ff),
      .rd_data (rd_raw)
   );

   assign rd_entry   = entry_type'(rd_raw);
   assign mix        = mul_ff ^ (mul_ff >> 16);
   // remainder by reciprocal: quotient estimate may be one low, fixed by one subtract
   assign recip_prod = 96'(hash_ff) * 96'(HASH_RECIP);
   assign rem_wide   = hash_ff - 32'(64'(quo_ff) * 64'(ENTRIES));
   assign rem_fix    = (rem_ff >= (IDX_W+1)'(ENTRIES)) ?
                       rem_ff - (IDX_W+1)'(ENTRIES) : rem_ff;
   assign idx_step   = (idx_ff == IDX_W'(ENTRIES - 1)) ? '0 : idx_ff + 1'b1;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      mul_in     = mul_ff;
      hash_in    = hash_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      idx_in     = idx_ff;
      n_in       = n_ff;
      clr_rsp_in = clr_rsp_ff;
      item_take  = 1'b0;
      wr_en      = 1'b0;
      wr_entry   = '0;
      out_push   = 1'b0;
      out_rsp.echo_value = cur_ff.value;
      out_rsp.matched    = 1'b0;
      out_rsp.status     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && (ocnt_ff != 2'd2)) begin
               item_take = 1'b1;
               cur_in    = item;
               mul_in    = item.value * HASH_MUL;
               unique case (item.op)
                  OP_CLEAR: begin
                     idx_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLR;
                  end
                  OP_NOP: begin
                     out_push           = 1'b1;
                     out_rsp.echo_value = item.value;
                  end
                  default: state_in = ST_MIX;
               endcase
            end
         end
         ST_MIX: begin
            n_in = '0;
            if (IS_POW2) begin
               idx_in   = mix[IDX_W-1:0];
               state_in = ST_RD;
            end else begin
               hash_in  = mix;
               state_in = ST_QUO;
            end
         end
         ST_QUO: begin
            quo_in   = recip_prod[HASH_SHIFT +: 32];
            state_in = ST_REM;
         end
         ST_REM: begin
            rem_in   = rem_wide[IDX_W:0];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            idx_in   = rem_fix[IDX_W-1:0];
            state_in = ST_RD;
         end
         ST_RD: state_in = ST_CMP;
         ST_CMP: begin
            if (!rd_entry.occupied) begin
               // free slot: load inserts, probe misses
               out_push = 1'b1;
               state_in = ST_IDLE;
               if (cur_ff.op == OP_LOAD) begin
                  wr_en             = 1'b1;
                  wr_entry.occupied = 1'b1;
                  wr_entry.count    = COUNT_W'(1);
                  wr_entry.key      = cur_ff.value;
               end
            end else if (rd_entry.key == cur_ff.value) begin
               out_push = 1'b1;
               state_in = ST_IDLE;
               wr_entry = rd_entry;
               if (cur_ff.op == OP_LOAD) begin
                  if (rd_entry.count != COUNT_MAX) begin
                     wr_en          = 1'b1;
                     wr_entry.count = rd_entry.count + 1'b1;
                  end
               end else if (rd_entry.count != '0) begin
                  wr_en           = 1'b1;
                  wr_entry.count  = rd_entry.count - 1'b1;
                  out_rsp.matched = 1'b1;
               end
            end else if (n_ff == IDX_W'(ENTRIES - 1)) begin
               // whole table walked, value absent
               out_push       = 1'b1;
               out_rsp.status = (cur_ff.op == OP_LOAD);
               state_in       = ST_IDLE;
            end else begin
               idx_in   = idx_step;
               n_in     = n_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_CLR: begin
            wr_en  = 1'b1;
            idx_in = idx_step;
            if (idx_ff == IDX_W'(ENTRIES - 1)) begin
               out_push           = clr_rsp_ff;
               out_rsp.echo_value = '0;
               clr_rsp_in         = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLR;
         idx_ff     <= '0;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      mul_ff  <= mul_in;
      hash_ff <= hash_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      n_ff    <= n_in;
   end

   // result queue
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp_data  = oq_ff[ord_ff];
   assign out_pop   = rsp_pop && !rsp_empty;

   always_comb begin
      owr_in  = out_push ? !owr_ff : owr_ff;
      ord_in  = out_pop ? !ord_ff : ord_ff;
      ocnt_in = ocnt_ff + 2'(out_push) - 2'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= 1'b0;
         ord_ff  <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         owr_ff  <= owr_in;
         ord_ff  <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         oq_ff[owr_ff] <= out_rsp;
      end
   end

   // checks
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("back state not one-hot");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (ocnt_ff != 2'd2 || out_pop)) else $error("result queue overflow");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      item_take |-> state_ff == ST_IDLE) else $error("item taken while busy");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff != 2'd3) else $error("result count out of range");
endmodule

// ===== rtl/multiset_intersection_counter_top.sv =====
// top level of the multiset intersection counter: front decode, back table walk
// load/probe: hash, then remainder (quotient, remainder, fix) when ENTRIES is not a power
// of two, then a read and compare per slot walked; undefined action: result at accept
// clear: writes every slot, then gives its result; one item in the table walk at a time,
// so a new load/probe is taken only after the previous item has given its result
// reset: synchronous; a clearing pass over every table slot runs first, beats queue meanwhile
module multiset_intersection_counter_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mic_pkg::req_type req_data,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output mic_pkg::rsp_type rsp_data
);
   import mic_pkg::*;

   logic     item_valid;
   logic     item_take;
   work_type item;

   mic_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (push),
      .req_data   (req_data),
      .req_full   (full),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   mic_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_empty  (empty),
      .rsp_pop    (pop),
      .rsp_data   (rsp_data)
   );
endmodule

// ===== sim/multiset_intersection_counter_top_test.sv =====
// testbench for the multiset intersection counter: directed table, table fill, then random jobs
`timescale 1ns / 1ps

module multiset_intersection_counter_top_test;
   import mic_pkg::*;

   logic    clock;
   logic    reset;
   logic    push;
   req_type req_data;
   logic    full;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   // shadow copy of the count table
   logic [31:0]        table_key   [ENTRIES];
   logic [COUNT_W-1:0] table_count [ENTRIES];
   bit                 table_used  [ENTRIES];
   int unsigned        used_slots;

   rsp_type expected_q[$];
   int      error_count;
   int      beats_sent;
   int      beats_seen;
   int      load_total, probe_total, match_total, drop_total, clear_total;

   // directed rows, expected result typed in where it is obvious
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type result;
   } row_type;

   multiset_intersection_counter_top DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // clock, period 2 ns
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // hard stop for a hung run
   initial begin
      #4000000;
      $display("multiset_intersection_counter_top verification failed");
      $finish;
   end

   // home slot of a value
   function automatic int unsigned home_slot(logic [31:0] v);
      logic [31:0] h;
      h = v * HASH_MUL;
      h = h ^ (h >> 16);
      return h % ENTRIES;
   endfunction

   // slot holding v, or first free slot on its path, or -1 when absent and full
   function automatic int find_slot(logic [31:0] v, output bit hit);
      int unsigned idx;
      hit = 1'b0;
      idx = home_slot(v);
      for (int n = 0; n < ENTRIES; n++) begin
         if (!table_used[idx]) return idx;
         if (table_key[idx] == v) begin
            hit = 1'b1;
            return idx;
         end
         idx = (idx + 1) % ENTRIES;
      end
      return -1;
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < ENTRIES; i++) begin
         table_used[i]  = 1'b0;
         table_count[i] = '0;
      end
      used_slots = 0;
   endfunction

   // next state of the table and the result of one accepted beat
   function automatic rsp_type count_update(req_type r);
      rsp_type res;
      bit      hit;
      int      slot;
      res.echo_value = r.value;
      res.matched    = 1'b0;
      res.status     = 1'b0;
      case (op_type'(r.action))
         OP_LOAD: begin
            load_total++;
            slot = find_slot(r.value, hit);
            if (slot < 0) begin
               res.status = 1'b1;
               drop_total++;
            end else if (hit) begin
               if (table_count[slot] != COUNT_MAX) table_count[slot]++;
            end else begin
               table_used[slot]  = 1'b1;
               table_key[slot]   = r.value;
               table_count[slot] = 1;
               used_slots++;
            end
         end
         OP_PROBE: begin
            probe_total++;
            slot = find_slot(r.value, hit);
            if (slot >= 0 && hit && table_count[slot] != 0) begin
               table_count[slot]--;
               res.matched = 1'b1;
               match_total++;
            end
         end
         OP_CLEAR: begin
            clear_total++;
            clear_table();
            res.echo_value = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   // offer one beat after a random gap, predict it once accepted
   task automatic send_beat(req_type r, output rsp_type res);
      int gap;
      gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
      @(negedge clock);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      res = count_update(r);
      expected_q = {expected_q, res};
      beats_sent++;
   endtask

   task automatic send_op(op_type op, logic [31:0] v);
      req_type r;
      rsp_type res;
      r.action = op;
      r.value  = v;
      send_beat(r, res);
   endtask

   // value biased toward the extremes
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // a value landing in the same home slot as v
   function automatic logic [31:0] colliding_value(logic [31:0] v);
      logic [31:0] c;
      do c = $urandom; while (home_slot(c) != home_slot(v) || c == v);
      return c;
   endfunction

   // compare one result beat against the oldest prediction
   task automatic check_beat(rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         $error("result beat with nothing expected: echo_value %0h", got.echo_value);
         error_count++;
         return;
      end
      want = expected_q.pop_front();
      if (got.echo_value !== want.echo_value) begin
         $error("echo_value expected %0h actual %0h", want.echo_value, got.echo_value);
         error_count++;
      end
      if (got.matched !== want.matched) begin
         $error("matched expected %0b actual %0b", want.matched, got.matched);
         error_count++;
      end
      if (got.status !== want.status) begin
         $error("status expected %0b actual %0b", want.status, got.status);
         error_count++;
      end
   endtask

   // result side, with one long hold-off to back the block up
   initial begin
      int gap;
      pop <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (beats_seen == 60) begin
            pop <= 1'b0;
            for (int c = 0; c < 400; c++) @(negedge clock);
         end else begin
            gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
            if (gap > 0) begin
               pop <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         check_beat(rsp_data);
         beats_seen++;
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      row_type     rows[$];
      row_type     row;
      rsp_type     res;
      logic [31:0] pool[$];
      logic [31:0] v;
      int          random_items;
      bit          hit;

      error_count  = 0;
      beats_sent   = 0;
      beats_seen   = 0;
      load_total = 0; probe_total = 0; match_total = 0; drop_total = 0; clear_total = 0;
      clear_table();
      reset    <= 1'b1;
      push     <= 1'b0;
      req_data <= '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      rows = '{
         '{'{OP_PROBE, 32'sd5},            1, '{32'sd5, 1'b0, 1'b0}},
         '{'{OP_LOAD,  32'sh7fff_ffff},    1, '{32'sh7fff_ffff, 1'b0, 1'b0}},
         '{'{OP_LOAD,  32'sh8000_0000},    1, '{32'sh8000_0000, 1'b0, 1'b0}},
         '{'{OP_LOAD,  32'sh8000_0000},    1, '{32'sh8000_0000, 1'b0, 1'b0}},
         '{'{OP_PROBE, 32'sh8000_0000},    1, '{32'sh8000_0000, 1'b1, 1'b0}},
         '{'{OP_PROBE, 32'sh8000_0000},    1, '{32'sh8000_0000, 1'b1, 1'b0}},
         '{'{OP_PROBE, 32'sh8000_0000},    1, '{32'sh8000_0000, 1'b0, 1'b0}},
         '{'{OP_PROBE, 32'sh7fff_ffff},    1, '{32'sh7fff_ffff, 1'b1, 1'b0}},
         '{'{OP_NOP,   32'shdead_beef},    1, '{32'shdead_beef, 1'b0, 1'b0}},
         '{'{OP_LOAD,  32'sd0},            1, '{32'sd0, 1'b0, 1'b0}},
         '{'{OP_LOAD,  32'shffff_ffff},    1, '{32'shffff_ffff, 1'b0, 1'b0}},
         '{'{OP_PROBE, 32'sd0},            1, '{32'sd0, 1'b1, 1'b0}},
         '{'{OP_PROBE, 32'shffff_ffff},    1, '{32'shffff_ffff, 1'b1, 1'b0}},
         '{'{OP_PROBE, 32'sd12345},        1, '{32'sd12345, 1'b0, 1'b0}},
         '{'{OP_LOAD,  32'sh1234_5678},    0, '{32'sd0, 1'b0, 1'b0}},
         '{'{OP_CLEAR, 32'shffff_ffff},    1, '{32'sd0, 1'b0, 1'b0}},
         '{'{OP_PROBE, 32'sh7fff_ffff},    1, '{32'sh7fff_ffff, 1'b0, 1'b0}},
         '{'{OP_LOAD,  32'sd1},            1, '{32'sd1, 1'b0, 1'b0}},
         '{'{OP_PROBE, 32'sd1},            1, '{32'sd1, 1'b1, 1'b0}},
         '{'{OP_NOP,   32'sd0},            1, '{32'sd0, 1'b0, 1'b0}},
         '{'{OP_CLEAR, 32'sh5555_5555},    1, '{32'sd0, 1'b0, 1'b0}}
      };
      foreach (rows[i]) begin
         row = rows[i];
         send_beat(row.item, res);
         if (row.typed && res !== row.result) begin
            $error("directed row %0d: prediction %p differs from table %p", i, res, row.result);
            error_count++;
         end
      end

      // table full: distinct values on free home slots until every slot is used
      while (used_slots < ENTRIES) begin
         do v = $urandom; while (table_used[home_slot(v)]);
         send_op(OP_LOAD, v);
      end
      do v = $urandom; while (find_slot(v, hit) >= 0 || hit);
      send_op(OP_LOAD, v);
      send_op(OP_PROBE, v);
      send_op(OP_LOAD, table_key[$urandom_range(0, ENTRIES - 1)]);
      send_op(OP_PROBE, table_key[$urandom_range(0, ENTRIES - 1)]);
      send_op(OP_CLEAR, $urandom);

      // random jobs: load a pool, probe with it, some noise
      random_items = 0;
      while (random_items < 200) begin
         if ($urandom_range(0, 4) != 0) begin
            send_op(OP_CLEAR, $urandom);
            random_items++;
         end
         pool.delete();
         pool = {pool, pick_value()};
         repeat ($urandom_range(1, 7)) begin
            if ($urandom_range(0, 3) == 0) pool = {pool, colliding_value(pool[0])};
            else pool = {pool, pick_value()};
         end
         repeat ($urandom_range(1, 12)) begin
            send_op(OP_LOAD, pool[$urandom_range(0, pool.size() - 1)]);
            random_items++;
         end
         repeat ($urandom_range(1, 15)) begin
            case ($urandom_range(0, 9))
               0: send_op(OP_NOP, $urandom);
               1: send_op(OP_PROBE, $urandom);
               2: send_op(op_type'($urandom_range(0, 3)), $urandom);
               default: send_op(OP_PROBE, pool[$urandom_range(0, pool.size() - 1)]);
            endcase
            random_items++;
         end
      end

      @(negedge clock);
      push <= 1'b0;

      // drain, then give a late stray result time to show up
      while (expected_q.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      if (expected_q.size() != 0) begin
         $error("%0d expected results never arrived", expected_q.size());
         error_count++;
      end

      $display("sent %0d beats: %0d loads (%0d dropped on a full table), %0d probes",
               beats_sent, load_total, drop_total, probe_total);
      $display("%0d probe matches, %0d clears, a filled table and colliding values covered",
               match_total, clear_total);
      if (error_count == 0) begin
         $display("multiset_intersection_counter_top verification clean");
      end else begin
         $display("multiset_intersection_counter_top verification failed");
      end
      $finish;
   end

endmodule
